FILE: rtl/dqsd_pkg.sv
// ----------------------------------------------------------------------------
// dqsd_pkg: shared types and constants
// Request and response formats, action codes and status codes.
// ----------------------------------------------------------------------------
package dqsd_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_PEEK_FRONT = 3'd3,
      ACT_SEARCH     = 3'd4,
      ACT_DELETE     = 3'd5,
      ACT_CLEAR      = 3'd6,
      ACT_NOP        = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic [4:0]  entry_count;
   } rsp_type;

endpackage

FILE: rtl/deque_with_search_delete_top.sv
// ----------------------------------------------------------------------------
// deque_with_search_delete_top: deque with masked search and delete
// Ring buffer in one memory; physical slot = (head + position) mod DEPTH.
// Push, clear and no-op go from accept straight to S_RESP; pop and peek first
// read the front entry. Search checks entries from the front in turn. Delete:
// search first, then a read and a write per entry moved to close the gap (the shorter side is shifted).
// Next request taken once the previous has moved to the response register.
// Synchronous reset clears count and head and sets the mask to all ones.
// ----------------------------------------------------------------------------
module deque_with_search_delete_top #(
   parameter int DEPTH       = dqsd_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = dqsd_pkg::VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dqsd_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dqsd_pkg::rsp_type   rsp_data,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);
   import dqsd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_CHECK = 6'b000100,
      S_MOVRD = 6'b001000,
      S_MOVWR = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [31:0]            mask_ff;
   logic [2:0]             act_ff, act_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic                   front_ff, front_in;
   logic [1:0]             st_ff, st_in;
   logic [31:0]            res_ff, res_in;
   logic                   rv_ff, rv_in;
   logic [1:0]             ost_ff, ost_in;
   logic [31:0]            ores_ff, ores_in;
   logic [CW-1:0]          ocnt_ff, ocnt_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data, move_ff;
   logic                   accept;
   logic                   hit;

   dqsd_ring #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [CW:0] s;
      s = CW'(h) + {1'b0, p};
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_data  = '{status: ost_ff, result_value: ores_ff, entry_count: 5'(ocnt_ff)};
   assign hit = (((32'(rd_data) ^ 32'(key_ff)) & mask_ff) == 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 32'hFFFF_FFFF;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      pos_in   = pos_ff;
      front_in = front_ff;
      st_in    = st_ff;
      res_in   = res_ff;
      rv_in    = rv_ff && rsp_stall;
      ost_in   = ost_ff;
      ores_in  = ores_ff;
      ocnt_in  = ocnt_ff;
      wr_en    = 1'b0;
      wr_addr  = slot(head_ff, pos_ff);
      wr_data  = key_ff;
      rd_addr  = slot(head_ff, pos_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = req_data.action;
               key_in = VALUE_WIDTH'(req_data.value);
               pos_in = '0;
               st_in  = ST_DONE;
               res_in = '0;
               rd_addr = head_ff;
               unique case (action_type'(req_data.action))
                  ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        st_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = VALUE_WIDTH'(req_data.value);
                        if (req_data.action == ACT_PUSH_BACK) begin
                           wr_addr = slot(head_ff, count_ff);
                        end else begin
                           wr_addr = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
                           head_in = wr_addr;
                        end
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  ACT_POP_FRONT, ACT_PEEK_FRONT, ACT_SEARCH, ACT_DELETE: begin
                     if (count_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (act_ff == ACT_POP_FRONT || act_ff == ACT_PEEK_FRONT || hit) begin
               res_in = 32'(rd_data);
               if (act_ff == ACT_POP_FRONT) begin
                  head_in  = slot(head_ff, CW'(1));
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end else if (act_ff == ACT_DELETE) begin
                  front_in = (pos_ff < (count_ff >> 1));
                  if (pos_ff < (count_ff >> 1)) begin
                     if (pos_ff == '0) begin
                        head_in  = slot(head_ff, CW'(1));
                        count_in = count_ff - 1'b1;
                        state_in = S_RESP;
                     end else begin
                        pos_in   = pos_ff - 1'b1;
                        rd_addr  = slot(head_ff, pos_ff - 1'b1);
                        state_in = S_MOVRD;
                     end
                  end else if (pos_ff + 1'b1 == count_ff) begin
                     count_in = count_ff - 1'b1;
                     state_in = S_RESP;
                  end else begin
                     pos_in   = pos_ff + 1'b1;
                     rd_addr  = slot(head_ff, pos_ff + 1'b1);
                     state_in = S_MOVRD;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end else if (pos_ff + 1'b1 == count_ff) begin
               st_in    = ST_EMPTY;
               state_in = S_RESP;
            end else begin
               pos_in   = pos_ff + 1'b1;
               rd_addr  = slot(head_ff, pos_ff + 1'b1);
               state_in = S_SCAN;
            end
         end
         S_MOVRD: begin
            // rd_data holds entry at pos_ff; write it one step towards the gap
            state_in = S_MOVWR;
         end
         S_MOVWR: begin
            wr_en   = 1'b1;
            wr_data = move_ff;
            if (front_ff) begin
               wr_addr = slot(head_ff, pos_ff + 1'b1);
               if (pos_ff == '0) begin
                  head_in  = slot(head_ff, CW'(1));
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  pos_in   = pos_ff - 1'b1;
                  rd_addr  = slot(head_ff, pos_ff - 1'b1);
                  state_in = S_MOVRD;
               end
            end else begin
               wr_addr = slot(head_ff, pos_ff - 1'b1);
               if (pos_ff + 1'b1 == count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  rd_addr  = slot(head_ff, pos_ff + 1'b1);
                  state_in = S_MOVRD;
               end
            end
         end
         S_RESP: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ost_in   = st_ff;
               ores_in  = res_ff;
               ocnt_in  = count_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      front_ff <= front_in;
      st_ff    <= st_in;
      res_ff   <= res_in;
      ost_ff   <= ost_in;
      ores_ff  <= ores_in;
      ocnt_ff  <= ocnt_in;
      if (state_ff == S_MOVRD) begin
         move_ff <= rd_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count above depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE || !accept) && count_ff != $past(count_ff) && !$past(reset)
      |-> count_ff == $past(count_ff) - 1'b1 || count_ff == $past(count_ff) + 1'b1
          || count_ff == '0) else $error("count jumped");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.entry_count == 5'(DEPTH))
      else $error("full status with room");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accepting while busy");

endmodule

FILE: rtl/dqsd_ring.sv
// ----------------------------------------------------------------------------
// dqsd_ring: ring buffer storage
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dqsd_ring #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [VALUE_WIDTH-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [VALUE_WIDTH-1:0]   rd_data
);
   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: tb/deque_with_search_delete_top_tb.sv
// ----------------------------------------------------------------------------
// deque_with_search_delete_top_tb: self-checking bench for the masked deque
// Drives directed and random requests through the request channel under
// several idling phases, predicts each response with a behavioural deque and
// checks every field. The match mask is changed between phases while idle.
// ----------------------------------------------------------------------------
module deque_with_search_delete_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dqsd_pkg::*;

   localparam int DEPTH = 16;
   localparam int WDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // model state
   logic [31:0] dq_store[$];
   logic [31:0] dq_mask;
   rsp_type     pending_rsp[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   deque_with_search_delete_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic rsp_type apply_action(input req_type rq);
      rsp_type r;
      int      pos;
      r = '0;
      r.status = ST_DONE;
      case (action_type'(rq.action))
         ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (dq_store.size() >= DEPTH) r.status = ST_FULL;
            else if (rq.action == ACT_PUSH_BACK) dq_store.push_back(rq.value);
            else dq_store.push_front(rq.value);
         end
         ACT_POP_FRONT, ACT_PEEK_FRONT: begin
            if (dq_store.size() == 0) r.status = ST_EMPTY;
            else begin
               r.result_value = dq_store[0];
               if (rq.action == ACT_POP_FRONT) void'(dq_store.pop_front());
            end
         end
         ACT_SEARCH, ACT_DELETE: begin
            pos = -1;
            foreach (dq_store[i])
               if (pos < 0 && ((dq_store[i] ^ rq.value) & dq_mask) == 0) pos = i;
            if (pos < 0) r.status = ST_EMPTY;
            else begin
               r.result_value = dq_store[pos];
               if (rq.action == ACT_DELETE) dq_store.delete(pos);
            end
         end
         ACT_CLEAR: dq_store.delete();
         default: ;
      endcase
      r.entry_count = 5'(dq_store.size());
      return r;
   endfunction

   // response stall and checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               if (e.status != rsp_data.status) begin
                  $display("%0t: status exp %0d got %0d", $realtime, e.status,
                           rsp_data.status);
                  errors++;
               end
               if (e.result_value != rsp_data.result_value) begin
                  $display("%0t: value exp %h got %h", $realtime, e.result_value,
                           rsp_data.result_value);
                  errors++;
               end
               if (e.entry_count != rsp_data.entry_count) begin
                  $display("%0t: count exp %0d got %0d", $realtime, e.entry_count,
                           rsp_data.entry_count);
                  errors++;
               end
               n_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_request(input action_type act, input logic [31:0] val);
      req_type rq;
      rq.action = act;
      rq.value = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(apply_action(rq));
      n_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mask(input logic [31:0] m);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dq_mask = m;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return 32'(($urandom_range(7)));
         1: return 32'hFFFF_FFF8 | 32'($urandom_range(7));
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_request(ACT_POP_FRONT, 32'h0);
      send_request(ACT_PEEK_FRONT, 32'h0);
      send_request(ACT_SEARCH, 32'h0);
      send_request(ACT_DELETE, 32'hFFFF_FFFF);
      send_request(ACT_PUSH_BACK, 32'hFFFF_FFFF);
      send_request(ACT_PUSH_FRONT, 32'h0);
      send_request(ACT_PEEK_FRONT, 32'h0);
      send_request(ACT_SEARCH, 32'hFFFF_FFFF);
      send_request(ACT_DELETE, 32'h0);
      send_request(ACT_NOP, 32'hA5A5_A5A5);
      for (int i = 0; i < 16; i++) send_request(ACT_PUSH_BACK, 32'h100 + i);
      send_request(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
      send_request(ACT_POP_FRONT, 32'h0);
      send_request(ACT_DELETE, 32'h10F);
      send_request(ACT_SEARCH, 32'h1234);
      send_request(ACT_CLEAR, 32'h0);
   endtask

   task automatic test_random(input int n_items);
      action_type act;
      int         k;
      for (int i = 0; i < n_items; i++) begin
         k = $urandom_range(99);
         if (k < 25) act = ACT_PUSH_BACK;
         else if (k < 45) act = ACT_PUSH_FRONT;
         else if (k < 55) act = ACT_POP_FRONT;
         else if (k < 62) act = ACT_PEEK_FRONT;
         else if (k < 77) act = ACT_SEARCH;
         else if (k < 94) act = ACT_DELETE;
         else if (k < 97) act = ACT_CLEAR;
         else act = ACT_NOP;
         if ((act == ACT_SEARCH || act == ACT_DELETE) && dq_store.size() != 0
             && $urandom_range(1))
            send_request(act, dq_store[$urandom_range(dq_store.size() - 1)]
                              ^ ($urandom() & ~dq_mask));
         else send_request(act, rand_value());
      end
   endtask

   task automatic test_idling_phases();
      send_idle_pct = 0;  rsp_stall_pct = 0;  test_random(270);
      write_mask(32'h0000_0000);
      send_idle_pct = 83; rsp_stall_pct = 0;  test_random(270);
      write_mask(32'h0000_000F);
      send_idle_pct = 0;  rsp_stall_pct = 83; test_random(270);
      write_mask($urandom());
      send_idle_pct = 29; rsp_stall_pct = 29; test_random(270);
      write_mask(32'hFFFF_FFFF);
      send_idle_pct = 0;  rsp_stall_pct = 0;  test_random(230);
   endtask

   initial begin
      dq_mask = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_mask(32'hFFFF_FF00);
      test_directed();
      write_mask(32'hFFFF_FFFF);
      test_idling_phases();
      wait_idle();
      $display("Sent %0d requests, checked %0d responses across five idling phases",
               n_sent, n_checked);
      $display("and several mask settings including all-zero and all-one.");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
